// ===== design/stdisp_pkg.sv =====
`default_nettype none
package stdisp_pkg;

	localparam int TENSOR_WIDTH = 24;

	// register file
	localparam int THR_W   = 17;
	localparam int OFF_W   = 18;
	localparam int CFG_W   = 18;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_COHERENCE    = 1'b0,
		CFG_DISPARITY_OFFSET = 1'b1
	} cfg_idx_t;

	localparam logic [THR_W-1:0] MIN_COHERENCE_RST    = 17'd52429;
	localparam logic [OFF_W-1:0] DISPARITY_OFFSET_RST = 18'd0;

	// fixed-point layout
	localparam int DISP_W     = 18;
	localparam int ROOT_PAD   = 32;  // radicand is (x^2 + y^2) * 2^32
	localparam int DEN_SHIFT  = 16;  // x scaled to match the root
	localparam int NUM_SHIFT  = 31;  // 2 * |y| * 2^30
	localparam int QUOT_W     = 16;  // rounded tangent magnitude stays below 2^16

	localparam logic signed [DISP_W:0] DISP_MAX = 19'sd131071;
	localparam logic signed [DISP_W:0] DISP_MIN = -19'sd131072;

endpackage
`default_nettype wire

// ===== design/stdisp_if.sv =====
`default_nettype none
interface stdisp_pix_if #(
	parameter int TW = stdisp_pkg::TENSOR_WIDTH
) ();
	logic                 valid;
	logic                 ready;
	logic signed [TW-1:0] jxx;
	logic signed [TW-1:0] jxy;
	logic signed [TW-1:0] jyy;

	modport source (output valid, jxx, jxy, jyy, input ready);
	modport sink   (input valid, jxx, jxy, jyy, output ready);
endinterface

interface stdisp_res_if ();
	logic                                    valid;
	logic                                    ready;
	logic signed [stdisp_pkg::DISP_W-1:0]    disparity;
	logic                                    valid_res;

	modport source (output valid, disparity, valid_res, input ready);
	modport sink   (input valid, disparity, valid_res, output ready);
endinterface
`default_nettype wire

// ===== design/stdisp_sqrt.sv =====
`default_nettype none
// Pipelined integer square root, one root bit per stage.
module stdisp_sqrt #(
	parameter int RB  = 41,
	parameter int SBW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_vld,
	input  wire logic [2*RB-1:0] rad,
	input  wire logic [SBW-1:0]  sb_in,
	output logic                 out_vld,
	output logic [RB-1:0]        root,
	output logic [SBW-1:0]       sb_out
);

	logic            v_s    [RB+1];
	logic [2*RB-1:0] rad_s  [RB+1];
	logic [RB:0]     rem_s  [RB+1];
	logic [RB-1:0]   root_s [RB+1];
	logic [SBW-1:0]  sb_s   [RB+1];

	assign v_s[0]    = in_vld;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sb_s[0]   = sb_in;

	for (genvar k = 0; k < RB; k++) begin : g_stage
		logic [RB+1:0] cand;
		logic [RB+1:0] trial;
		logic          ge;

		always_comb begin
			cand  = {rem_s[k][RB-1:0], rad_s[k][2*RB-1 -: 2]};
			trial = {root_s[k], 2'b01};
			ge    = (cand >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][2*RB-3:0], 2'b00};
				rem_s[k+1]  <= ge ? (RB+1)'(cand - trial) : cand[RB:0];
				root_s[k+1] <= {root_s[k][RB-2:0], ge};
				sb_s[k+1]   <= sb_s[k];
			end
		end
	end

	assign out_vld = v_s[RB];
	assign root    = root_s[RB];
	assign sb_out  = sb_s[RB];

endmodule
`default_nettype wire

// ===== design/stdisp_div.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module stdisp_div #(
	parameter int NW  = 57,
	parameter int DW  = 43,
	parameter int QB  = 16,
	parameter int SBW = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire logic [NW-1:0]  num,
	input  wire logic [DW-1:0]  den,
	input  wire logic [SBW-1:0] sb_in,
	output logic                out_vld,
	output logic [QB-1:0]       quot,
	output logic [SBW-1:0]      sb_out
);

	localparam int RW = (NW > DW + QB) ? NW : DW + QB;

	logic          v_s   [QB+1];
	logic [RW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic [SBW-1:0] sb_s [QB+1];

	assign v_s[0]   = in_vld;
	assign rem_s[0] = RW'(num);
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign sb_s[0]  = sb_in;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int SH = QB - 1 - k;
		logic [RW-1:0] dsh;
		logic          ge;

		always_comb begin
			dsh = RW'(den_s[k]) << SH;
			ge  = (rem_s[k] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= {q_s[k][QB-2:0], ge};
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign out_vld = v_s[QB];
	assign quot    = q_s[QB];
	assign sb_out  = sb_s[QB];

endmodule
`default_nettype wire

// ===== design/structure_tensor_to_disparity.sv =====
`default_nettype none
// Channel   Dir   Payload                          Handshake
// pixel     in    jxx, jxy, jyy (signed, TW bits)  valid / ready
// result    out   disparity (s18 Q3.14), valid_res valid / ready
// cfg_*     in    cfg_index, cfg_data              cfg_we, no back-pressure
//
// One pixel per cycle while result is not stalled; the pipeline is built from
// three front stages, TENSOR_WIDTH + 17 root stages, one compare stage,
// 16 divider stages and the output register. The root and divider chains set its depth.
// Reset clears every stage valid and loads the register reset values.
// A stall on result freezes the whole pipeline; pixel.ready drops in the same
// cycle, and no request is lost or repeated.
module structure_tensor_to_disparity #(
	parameter int TENSOR_WIDTH = stdisp_pkg::TENSOR_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	stdisp_pix_if.sink                               pixel,
	stdisp_res_if.source                             result,
	input  wire logic                                cfg_we,
	input  wire logic [stdisp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [stdisp_pkg::CFG_W-1:0]        cfg_data
);

	localparam int TW   = TENSOR_WIDTH;
	localparam int TH_W = stdisp_pkg::THR_W;
	localparam int RB   = TW + 17;          // root bits
	localparam int MW   = 2 * TW + 2;       // x^2 + y^2
	localparam int TAW  = TW + 1 + TH_W;    // thr * |s|
	localparam int DNW  = TW + 18;          // x * 2^16 + r
	localparam int DDW  = DNW + 1;          // divisor 2 * den
	localparam int NW   = TW + 1 + stdisp_pkg::NUM_SHIFT + 1;
	localparam int QB   = stdisp_pkg::QUOT_W;
	localparam int SQW  = TW + (TW + 1) + TAW + 2;

	// configuration registers
	logic [TH_W-1:0]                     thr_q;
	logic signed [stdisp_pkg::OFF_W-1:0] off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= stdisp_pkg::MIN_COHERENCE_RST;
			off_q <= stdisp_pkg::DISPARITY_OFFSET_RST;
		end else if (cfg_we) begin
			case (stdisp_pkg::cfg_idx_t'(cfg_index))
				stdisp_pkg::CFG_MIN_COHERENCE:    thr_q <= cfg_data[TH_W-1:0];
				stdisp_pkg::CFG_DISPARITY_OFFSET: off_q <= cfg_data[stdisp_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless the output holds an untaken request
	logic en;
	logic v_s5;
	assign en          = !v_s5 || result.ready;
	assign pixel.ready = en;

	// stage 1: x = jyy - jxx, |y|, |jxx + jyy|
	logic signed [TW:0] x_c, s_c;
	logic [TW:0]        ay_c, as_c;
	always_comb begin
		x_c  = {pixel.jyy[TW-1], pixel.jyy} - {pixel.jxx[TW-1], pixel.jxx};
		s_c  = {pixel.jyy[TW-1], pixel.jyy} + {pixel.jxx[TW-1], pixel.jxx};
		ay_c = pixel.jxy[TW-1] ? {-{pixel.jxy[TW-1], pixel.jxy}} << 1
		                       : {pixel.jxy[TW-1], pixel.jxy} << 1;
		as_c = s_c[TW] ? -s_c : s_c;
	end

	logic          v_s1, pos_s1, neg_s1;
	logic [TW-1:0] ax_s1;
	logic [TW:0]   ay_s1, as_s1;

	// stage 2: squares and the threshold product
	logic              v_s2, pos_s2, neg_s2;
	logic [TW-1:0]     ax_s2;
	logic [TW:0]       ay_s2;
	logic [2*TW-1:0]   xx_s2;
	logic [2*TW+1:0]   yy_s2;
	logic [TAW-1:0]    ta_s2;

	// stage 3: x^2 + y^2
	logic              v_s3, pos_s3, neg_s3;
	logic [TW-1:0]     ax_s3;
	logic [TW:0]       ay_s3;
	logic [MW-1:0]     mag_s3;
	logic [TAW-1:0]    ta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= !x_c[TW] && (x_c != '0);
			neg_s1 <= pixel.jxy[TW-1];
			ax_s1  <= x_c[TW-1:0];
			ay_s1  <= ay_c;
			as_s1  <= as_c;

			pos_s2 <= pos_s1;
			neg_s2 <= neg_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			xx_s2  <= ax_s1 * ax_s1;
			yy_s2  <= ay_s1 * ay_s1;
			ta_s2  <= thr_q * as_s1;

			pos_s3 <= pos_s2;
			neg_s3 <= neg_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			mag_s3 <= MW'(xx_s2) + yy_s2;
			ta_s3  <= ta_s2;
		end
	end

	// root chain: r = floor(sqrt((x^2 + y^2) * 2^32))
	logic              sq_vld;
	logic [RB-1:0]     sq_root;
	logic [SQW-1:0]    sq_sb;
	logic [TW-1:0]     ax_r;
	logic [TW:0]       ay_r;
	logic [TAW-1:0]    ta_r;
	logic              pos_r, neg_r;

	stdisp_sqrt #(.RB(RB), .SBW(SQW)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s3),
		.rad     ({mag_s3, stdisp_pkg::ROOT_PAD'(0)}),
		.sb_in   ({ax_s3, ay_s3, ta_s3, pos_s3, neg_s3}),
		.out_vld (sq_vld),
		.root    (sq_root),
		.sb_out  (sq_sb)
	);

	assign {ax_r, ay_r, ta_r, pos_r, neg_r} = sq_sb;

	// stage 4: coherence test as x > 0 and r >= thr * |s|, build dividend and divisor
	logic           v_s4, ok_s4, neg_s4;
	logic [NW-1:0]  num_s4;
	logic [DDW-1:0] dvs_s4;
	logic [DNW-1:0] den_c;

	assign den_c = (DNW'(ax_r) << stdisp_pkg::DEN_SHIFT) + DNW'(sq_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4  <= pos_r && (TAW'(sq_root) >= ta_r);
			neg_s4 <= neg_r;
			num_s4 <= (NW'(ay_r) << stdisp_pkg::NUM_SHIFT) + NW'(den_c);
			dvs_s4 <= {den_c, 1'b0};
		end
	end

	// rounded quotient (2*|y|*2^30 + den) / (2*den)
	logic          dv_vld;
	logic [QB-1:0] dv_q;
	logic          ok_d, neg_d;

	stdisp_div #(.NW(NW), .DW(DDW), .QB(QB), .SBW(2)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s4),
		.num     (num_s4),
		.den     (dvs_s4),
		.sb_in   ({ok_s4, neg_s4}),
		.out_vld (dv_vld),
		.quot    (dv_q),
		.sb_out  ({ok_d, neg_d})
	);

	// stage 5: sign, offset, clamp, zero for rejected pixels; this is the output register
	logic signed [stdisp_pkg::DISP_W:0]   sum_c;
	logic signed [stdisp_pkg::DISP_W:0]   t_c;
	logic signed [stdisp_pkg::DISP_W-1:0] disp_s5;
	logic                                 ok_s5;

	always_comb begin
		t_c   = neg_d ? -$signed({3'b000, dv_q}) : $signed({3'b000, dv_q});
		sum_c = t_c + {off_q[stdisp_pkg::OFF_W-1], off_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5 <= ok_d;
			if (!ok_d) begin
				disp_s5 <= '0;
			end else if (sum_c > stdisp_pkg::DISP_MAX) begin
				disp_s5 <= stdisp_pkg::DISP_MAX[stdisp_pkg::DISP_W-1:0];
			end else if (sum_c < stdisp_pkg::DISP_MIN) begin
				disp_s5 <= stdisp_pkg::DISP_MIN[stdisp_pkg::DISP_W-1:0];
			end else begin
				disp_s5 <= sum_c[stdisp_pkg::DISP_W-1:0];
			end
		end
	end

	assign result.valid     = v_s5;
	assign result.disparity = disp_s5;
	assign result.valid_res = ok_s5;

	// rejected pixels always carry zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.valid_res |-> result.disparity == '0)
		else $error("rejected pixel with nonzero disparity");

	// tangent magnitude never exceeds 2^14 + 1 for a coherent pixel
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld && ok_d |-> dv_q <= QB'(16385))
		else $error("tangent magnitude out of range");

	// a frozen pipeline keeps the occupancy of stages 1 and 4
	a_hold_front: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s4))
		else $error("stage valid moved during stall");

	// a coherent pixel must have passed the x > 0 test
	a_ok_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ok_s4 |-> $past(pos_r) || !$past(en))
		else $error("coherent pixel without positive x");

endmodule
`default_nettype wire
